// File: rtl/core/bsdf_pkg.sv
// ----------------------------------------------------------------------------
// Bone spring-damper force: shared package
// Widths, codes, latency and the sideband word that travels down the pipeline.
// ----------------------------------------------------------------------------
package bsdf_pkg;

   localparam int FRAC_BITS = 16;

   localparam int POS_W   = 27;
   localparam int VEL_W   = 24;
   localparam int LEN_W   = 21;
   localparam int DAMP_W  = 22;
   localparam int HINGE_W = 2;
   localparam int FORCE_W = 22;
   localparam int ROT_W   = 29;

   localparam int DIFF_W = POS_W + 1;          // end-to-end difference
   localparam int RAD_W  = 2 * DIFF_W;         // sum of squares
   localparam int ROOT_W = DIFF_W;             // integer square root
   localparam int QUOT_W = FRAC_BITS + 1;      // unit component magnitude
   localparam int NUM_W  = DIFF_W + FRAC_BITS; // divider numerator
   localparam int UNIT_W = FRAC_BITS + 2;      // signed unit component
   localparam int RV_W   = VEL_W + 1;          // relative velocity

   localparam int FORCE_LIM = 1048576;
   localparam int ROT_LIM   = 134217728;

   localparam int FRONT_STAGES = 3;
   localparam int FORCE_STAGES = 9;
   localparam int LATENCY      = FRONT_STAGES + ROOT_W + QUOT_W + FORCE_STAGES;

   localparam logic [HINGE_W-1:0] HINGE_NONE    = 2'd0;
   localparam logic [HINGE_W-1:0] HINGE_PIVOT_A = 2'd1;
   localparam logic [HINGE_W-1:0] HINGE_PIVOT_B = 2'd2;

   localparam logic [HINGE_W-1:0] TARGET_NONE = 2'd0;
   localparam logic [HINGE_W-1:0] TARGET_A    = 2'd1;
   localparam logic [HINGE_W-1:0] TARGET_B    = 2'd2;

   typedef struct packed {
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic signed [RV_W-1:0]   rvx;
      logic signed [RV_W-1:0]   rvy;
      logic signed [VEL_W-1:0]  vax;
      logic signed [VEL_W-1:0]  vay;
      logic signed [VEL_W-1:0]  vbx;
      logic signed [VEL_W-1:0]  vby;
      logic [LEN_W-1:0]         rest;
      logic [LEN_W-1:0]         k;
      logic [HINGE_W-1:0]       hinge;
      logic signed [DAMP_W-1:0] damp;
      logic                     skip;
   } bone_side_type;

endpackage

// File: rtl/core/bsdf_sqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One root bit is settled per register stage; sideband word travels alongside.
// ----------------------------------------------------------------------------
module bsdf_sqrt
   import bsdf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [RAD_W-1:0]    in_radicand,
   input  bone_side_type       in_side,
   output logic                out_valid,
   output logic [ROOT_W-1:0]   out_root,
   output bone_side_type       out_side
);

   logic [RAD_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   bone_side_type     side_ff [ROOT_W];
   logic [ROOT_W-1:0] valid_ff;

   for (genvar j = 0; j < ROOT_W; j++) begin : g_step
      localparam int B = ROOT_W - 1 - j;
      logic [RAD_W-1:0]  rem_prev;
      logic [ROOT_W-1:0] root_prev;
      bone_side_type     side_prev;
      logic              valid_prev;
      logic [RAD_W:0]    trial;
      logic              fit;
      logic [RAD_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;

      if (j == 0) begin : g_first
         assign rem_prev   = in_radicand;
         assign root_prev  = '0;
         assign side_prev  = in_side;
         assign valid_prev = in_valid;
      end else begin : g_next
         assign rem_prev   = rem_ff[j-1];
         assign root_prev  = root_ff[j-1];
         assign side_prev  = side_ff[j-1];
         assign valid_prev = valid_ff[j-1];
      end

      // (q + 2^B)^2 - q^2 = q*2^(B+1) + 2^(2B)
      assign trial   = ((RAD_W+1)'(root_prev) << (B + 1)) + ((RAD_W+1)'(1) << (2 * B));
      assign fit     = {1'b0, rem_prev} >= trial;
      assign rem_in  = fit ? rem_prev - RAD_W'(trial) : rem_prev;
      assign root_in = fit ? (root_prev | (ROOT_W'(1) << B)) : root_prev;

      always_ff @(posedge clock) begin
         rem_ff[j]  <= rem_in;
         root_ff[j] <= root_in;
         side_ff[j] <= side_prev;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else begin
            valid_ff[j] <= valid_prev;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

// File: rtl/core/bsdf_div.sv
// ----------------------------------------------------------------------------
// Pipelined unit-vector divider
// Two restoring dividers, |dx|*2^F/dist and |dy|*2^F/dist, one bit per stage.
// ----------------------------------------------------------------------------
module bsdf_div
   import bsdf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [ROOT_W-1:0]   in_dist,
   input  bone_side_type       in_side,
   output logic                out_valid,
   output logic [QUOT_W-1:0]   out_qx,
   output logic [QUOT_W-1:0]   out_qy,
   output logic [ROOT_W-1:0]   out_dist,
   output bone_side_type       out_side
);

   logic [NUM_W-1:0]  rem_x_ff [QUOT_W];
   logic [NUM_W-1:0]  rem_y_ff [QUOT_W];
   logic [QUOT_W-1:0] q_x_ff   [QUOT_W];
   logic [QUOT_W-1:0] q_y_ff   [QUOT_W];
   logic [ROOT_W-1:0] dist_ff  [QUOT_W];
   bone_side_type     side_ff  [QUOT_W];
   logic [QUOT_W-1:0] valid_ff;

   logic [DIFF_W-1:0] mag_x;
   logic [DIFF_W-1:0] mag_y;

   assign mag_x = in_side.dx[DIFF_W-1] ? DIFF_W'(-in_side.dx) : DIFF_W'(in_side.dx);
   assign mag_y = in_side.dy[DIFF_W-1] ? DIFF_W'(-in_side.dy) : DIFF_W'(in_side.dy);

   for (genvar j = 0; j < QUOT_W; j++) begin : g_step
      localparam int B = QUOT_W - 1 - j;
      logic [NUM_W-1:0]  rx_prev;
      logic [NUM_W-1:0]  ry_prev;
      logic [QUOT_W-1:0] qx_prev;
      logic [QUOT_W-1:0] qy_prev;
      logic [ROOT_W-1:0] dist_prev;
      bone_side_type     side_prev;
      logic              valid_prev;
      logic [NUM_W:0]    trial;
      logic              fit_x;
      logic              fit_y;

      if (j == 0) begin : g_first
         assign rx_prev    = {mag_x, FRAC_BITS'(0)};
         assign ry_prev    = {mag_y, FRAC_BITS'(0)};
         assign qx_prev    = '0;
         assign qy_prev    = '0;
         assign dist_prev  = in_dist;
         assign side_prev  = in_side;
         assign valid_prev = in_valid;
      end else begin : g_next
         assign rx_prev    = rem_x_ff[j-1];
         assign ry_prev    = rem_y_ff[j-1];
         assign qx_prev    = q_x_ff[j-1];
         assign qy_prev    = q_y_ff[j-1];
         assign dist_prev  = dist_ff[j-1];
         assign side_prev  = side_ff[j-1];
         assign valid_prev = valid_ff[j-1];
      end

      assign trial = (NUM_W+1)'(dist_prev) << B;
      assign fit_x = {1'b0, rx_prev} >= trial;
      assign fit_y = {1'b0, ry_prev} >= trial;

      always_ff @(posedge clock) begin
         rem_x_ff[j] <= fit_x ? rx_prev - NUM_W'(trial) : rx_prev;
         rem_y_ff[j] <= fit_y ? ry_prev - NUM_W'(trial) : ry_prev;
         q_x_ff[j]   <= fit_x ? (qx_prev | (QUOT_W'(1) << B)) : qx_prev;
         q_y_ff[j]   <= fit_y ? (qy_prev | (QUOT_W'(1) << B)) : qy_prev;
         dist_ff[j]  <= dist_prev;
         side_ff[j]  <= side_prev;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else begin
            valid_ff[j] <= valid_prev;
         end
      end
   end

   assign out_valid = valid_ff[QUOT_W-1];
   assign out_qx    = q_x_ff[QUOT_W-1];
   assign out_qy    = q_y_ff[QUOT_W-1];
   assign out_dist  = dist_ff[QUOT_W-1];
   assign out_side  = side_ff[QUOT_W-1];

endmodule

// File: rtl/core/bsdf_force.sv
// ----------------------------------------------------------------------------
// Force stages
// Nine register stages: spring and damping along the bone, clamp, tangential
// damping, saturation and the output register.
// ----------------------------------------------------------------------------
module bsdf_force
   import bsdf_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic [QUOT_W-1:0]         in_qx,
   input  logic [QUOT_W-1:0]         in_qy,
   input  logic [ROOT_W-1:0]         in_dist,
   input  bone_side_type             in_side,
   input  logic [LEN_W-1:0]          max_force,
   output logic                      out_valid,
   output logic signed [FORCE_W-1:0] out_force_x,
   output logic signed [FORCE_W-1:0] out_force_y,
   output logic signed [ROT_W-1:0]   out_rot_force_x,
   output logic signed [ROT_W-1:0]   out_rot_force_y,
   output logic [HINGE_W-1:0]        out_rot_target,
   output logic                      out_skipped
);

   localparam int ERR_W   = ROOT_W + 2;
   localparam int DOT_W   = RV_W + UNIT_W;
   localparam int ALONG_W = DOT_W + 1 - FRAC_BITS;
   localparam int SPR_W   = ERR_W + 1;
   localparam int FK_W    = SPR_W + LEN_W + 1;
   localparam int FKS_W   = FK_W - FRAC_BITS;
   localparam int FP_W    = FORCE_W + UNIT_W;
   localparam int FPS_W   = FP_W - FRAC_BITS;
   localparam int MV_W    = VEL_W + UNIT_W;
   localparam int TV_W    = MV_W + 1 - FRAC_BITS;
   localparam int NTV_W   = TV_W + 1;
   localparam int GP_W    = NTV_W + DAMP_W;
   localparam int G_W     = GP_W - FRAC_BITS;
   localparam int RP_W    = UNIT_W + G_W;
   localparam int RPS_W   = RP_W - FRAC_BITS;

   localparam logic signed [FPS_W-1:0]   F_HI  = FPS_W'(FORCE_LIM);
   localparam logic signed [FORCE_W-1:0] F_OUT = FORCE_W'(FORCE_LIM);
   localparam logic signed [RPS_W-1:0]   R_HI  = RPS_W'(ROT_LIM);
   localparam logic signed [ROT_W-1:0]   R_OUT = ROT_W'(ROT_LIM);

   logic [FORCE_STAGES-1:0] valid_ff;

   // Stage 0: signed unit vector and length error.
   logic signed [UNIT_W-1:0] qxs, qys;
   logic signed [UNIT_W-1:0] ux0_ff, uy0_ff;
   logic signed [ERR_W-1:0]  err0_ff;
   bone_side_type            side0_ff;

   assign qxs = signed'({1'b0, in_qx});
   assign qys = signed'({1'b0, in_qy});

   always_ff @(posedge clock) begin
      ux0_ff   <= in_side.dx[DIFF_W-1] ? -qxs : qxs;
      uy0_ff   <= in_side.dy[DIFF_W-1] ? -qys : qys;
      err0_ff  <= signed'(ERR_W'(in_dist)) - signed'(ERR_W'(in_side.rest));
      side0_ff <= in_side;
   end

   // Stage 1: velocity products along the bone; tangent and rotating end.
   logic signed [DOT_W-1:0]  px1_ff, py1_ff;
   logic signed [UNIT_W-1:0] tx_in, ty_in, tx1_ff, ty1_ff, ux1_ff, uy1_ff;
   logic signed [VEL_W-1:0]  vx_in, vy_in, vx1_ff, vy1_ff;
   logic [HINGE_W-1:0]       tgt_in, tgt1_ff;
   logic                     rot_in, rot1_ff, skip1_ff;
   logic signed [ERR_W-1:0]  err1_ff;
   logic [LEN_W-1:0]         k1_ff;
   logic signed [DAMP_W-1:0] damp1_ff;

   always_comb begin
      tx_in  = -uy0_ff;
      ty_in  = ux0_ff;
      vx_in  = side0_ff.vbx;
      vy_in  = side0_ff.vby;
      tgt_in = TARGET_NONE;
      rot_in = 1'b0;
      case (side0_ff.hinge)
         HINGE_PIVOT_A: begin
            tgt_in = TARGET_B;
            rot_in = 1'b1;
         end
         HINGE_PIVOT_B: begin
            tx_in  = uy0_ff;
            ty_in  = -ux0_ff;
            vx_in  = side0_ff.vax;
            vy_in  = side0_ff.vay;
            tgt_in = TARGET_A;
            rot_in = 1'b1;
         end
         default: begin
            tgt_in = TARGET_NONE;
         end
      endcase
      if (side0_ff.damp == '0) begin
         rot_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      px1_ff   <= side0_ff.rvx * ux0_ff;
      py1_ff   <= side0_ff.rvy * uy0_ff;
      tx1_ff   <= tx_in;
      ty1_ff   <= ty_in;
      vx1_ff   <= vx_in;
      vy1_ff   <= vy_in;
      tgt1_ff  <= tgt_in;
      rot1_ff  <= rot_in;
      skip1_ff <= side0_ff.skip;
      ux1_ff   <= ux0_ff;
      uy1_ff   <= uy0_ff;
      err1_ff  <= err0_ff;
      k1_ff    <= side0_ff.k;
      damp1_ff <= side0_ff.damp;
   end

   // Stage 2: projection of relative velocity; tangential velocity products.
   logic signed [DOT_W:0]     dot_sum;
   logic signed [ALONG_W-1:0] along2_ff;
   logic signed [MV_W-1:0]    mx2_ff, my2_ff;
   logic signed [UNIT_W-1:0]  tx2_ff, ty2_ff, ux2_ff, uy2_ff;
   logic [HINGE_W-1:0]        tgt2_ff;
   logic                      rot2_ff, skip2_ff;
   logic signed [ERR_W-1:0]   err2_ff;
   logic [LEN_W-1:0]          k2_ff;
   logic signed [DAMP_W-1:0]  damp2_ff;

   assign dot_sum = (DOT_W+1)'(px1_ff) + (DOT_W+1)'(py1_ff);

   always_ff @(posedge clock) begin
      along2_ff <= ALONG_W'(dot_sum >>> FRAC_BITS);
      mx2_ff    <= vx1_ff * tx1_ff;
      my2_ff    <= vy1_ff * ty1_ff;
      tx2_ff    <= tx1_ff;
      ty2_ff    <= ty1_ff;
      ux2_ff    <= ux1_ff;
      uy2_ff    <= uy1_ff;
      tgt2_ff   <= tgt1_ff;
      rot2_ff   <= rot1_ff;
      skip2_ff  <= skip1_ff;
      err2_ff   <= err1_ff;
      k2_ff     <= k1_ff;
      damp2_ff  <= damp1_ff;
   end

   // Stage 3: spring plus damping scalar; tangential velocity.
   logic signed [MV_W:0]     tv_sum;
   logic signed [SPR_W-1:0]  spr3_ff;
   logic signed [TV_W-1:0]   tv3_ff;
   logic signed [UNIT_W-1:0] tx3_ff, ty3_ff, ux3_ff, uy3_ff;
   logic [HINGE_W-1:0]       tgt3_ff;
   logic                     rot3_ff, skip3_ff;
   logic [LEN_W-1:0]         k3_ff;
   logic signed [DAMP_W-1:0] damp3_ff;

   assign tv_sum = (MV_W+1)'(mx2_ff) + (MV_W+1)'(my2_ff);

   always_ff @(posedge clock) begin
      spr3_ff  <= SPR_W'(err2_ff) + SPR_W'(along2_ff);
      tv3_ff   <= TV_W'(tv_sum >>> FRAC_BITS);
      tx3_ff   <= tx2_ff;
      ty3_ff   <= ty2_ff;
      ux3_ff   <= ux2_ff;
      uy3_ff   <= uy2_ff;
      tgt3_ff  <= tgt2_ff;
      rot3_ff  <= rot2_ff;
      skip3_ff <= skip2_ff;
      k3_ff    <= k2_ff;
      damp3_ff <= damp2_ff;
   end

   // Stage 4: scale by stiffness; negate tangential velocity.
   logic signed [LEN_W:0]    ks;
   logic signed [FK_W-1:0]   fk4_ff;
   logic signed [NTV_W-1:0]  ntv4_ff;
   logic signed [UNIT_W-1:0] tx4_ff, ty4_ff, ux4_ff, uy4_ff;
   logic [HINGE_W-1:0]       tgt4_ff;
   logic                     rot4_ff, skip4_ff;
   logic signed [DAMP_W-1:0] damp4_ff;

   assign ks = signed'({1'b0, k3_ff});

   always_ff @(posedge clock) begin
      fk4_ff   <= spr3_ff * ks;
      ntv4_ff  <= -NTV_W'(tv3_ff);
      tx4_ff   <= tx3_ff;
      ty4_ff   <= ty3_ff;
      ux4_ff   <= ux3_ff;
      uy4_ff   <= uy3_ff;
      tgt4_ff  <= tgt3_ff;
      rot4_ff  <= rot3_ff;
      skip4_ff <= skip3_ff;
      damp4_ff <= damp3_ff;
   end

   // Stage 5: clamp the scalar to the configured limit; damping product.
   logic signed [FKS_W-1:0]   fks, lim;
   logic signed [FORCE_W-1:0] f_in, f5_ff;
   logic signed [GP_W-1:0]    gp5_ff;
   logic signed [UNIT_W-1:0]  tx5_ff, ty5_ff, ux5_ff, uy5_ff;
   logic [HINGE_W-1:0]        tgt5_ff;
   logic                      rot5_ff, skip5_ff;

   assign fks = FKS_W'(fk4_ff >>> FRAC_BITS);
   assign lim = signed'(FKS_W'(max_force));

   always_comb begin
      if (fks > lim) begin
         f_in = FORCE_W'(lim);
      end else if (fks < -lim) begin
         f_in = FORCE_W'(-lim);
      end else begin
         f_in = FORCE_W'(fks);
      end
   end

   always_ff @(posedge clock) begin
      f5_ff    <= f_in;
      gp5_ff   <= ntv4_ff * damp4_ff;
      tx5_ff   <= tx4_ff;
      ty5_ff   <= ty4_ff;
      ux5_ff   <= ux4_ff;
      uy5_ff   <= uy4_ff;
      tgt5_ff  <= tgt4_ff;
      rot5_ff  <= rot4_ff;
      skip5_ff <= skip4_ff;
   end

   // Stage 6: force vector products; tangential damping scalar.
   logic signed [FP_W-1:0]   fx6_ff, fy6_ff;
   logic signed [G_W-1:0]    g6_ff;
   logic signed [UNIT_W-1:0] tx6_ff, ty6_ff;
   logic [HINGE_W-1:0]       tgt6_ff;
   logic                     rot6_ff, skip6_ff;

   always_ff @(posedge clock) begin
      fx6_ff   <= f5_ff * ux5_ff;
      fy6_ff   <= f5_ff * uy5_ff;
      g6_ff    <= G_W'(gp5_ff >>> FRAC_BITS);
      tx6_ff   <= tx5_ff;
      ty6_ff   <= ty5_ff;
      tgt6_ff  <= tgt5_ff;
      rot6_ff  <= rot5_ff;
      skip6_ff <= skip5_ff;
   end

   // Stage 7: saturate the bone force; tangential force products.
   logic signed [FPS_W-1:0]   fxs, fys;
   logic signed [FORCE_W-1:0] fx7_ff, fy7_ff;
   logic signed [RP_W-1:0]    rx7_ff, ry7_ff;
   logic [HINGE_W-1:0]        tgt7_ff;
   logic                      rot7_ff, skip7_ff;

   assign fxs = FPS_W'(fx6_ff >>> FRAC_BITS);
   assign fys = FPS_W'(fy6_ff >>> FRAC_BITS);

   always_ff @(posedge clock) begin
      fx7_ff   <= (fxs > F_HI) ? F_OUT : (fxs < -F_HI) ? -F_OUT : FORCE_W'(fxs);
      fy7_ff   <= (fys > F_HI) ? F_OUT : (fys < -F_HI) ? -F_OUT : FORCE_W'(fys);
      rx7_ff   <= tx6_ff * g6_ff;
      ry7_ff   <= ty6_ff * g6_ff;
      tgt7_ff  <= tgt6_ff;
      rot7_ff  <= rot6_ff;
      skip7_ff <= skip6_ff;
   end

   // Stage 8: saturate the tangential force and mask the special cases.
   logic signed [RPS_W-1:0] rxs, rys;
   logic                    rot_on;

   assign rxs    = RPS_W'(rx7_ff >>> FRAC_BITS);
   assign rys    = RPS_W'(ry7_ff >>> FRAC_BITS);
   assign rot_on = rot7_ff && !skip7_ff;

   always_ff @(posedge clock) begin
      out_force_x     <= skip7_ff ? '0 : fx7_ff;
      out_force_y     <= skip7_ff ? '0 : fy7_ff;
      out_rot_force_x <= !rot_on ? '0 :
                         (rxs > R_HI) ? R_OUT : (rxs < -R_HI) ? -R_OUT : ROT_W'(rxs);
      out_rot_force_y <= !rot_on ? '0 :
                         (rys > R_HI) ? R_OUT : (rys < -R_HI) ? -R_OUT : ROT_W'(rys);
      out_rot_target  <= rot_on ? tgt7_ff : TARGET_NONE;
      out_skipped     <= skip7_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[FORCE_STAGES-2:0], in_valid};
      end
   end

   assign out_valid = valid_ff[FORCE_STAGES-1];

endmodule

// File: rtl/core/bone_spring_damper_force.sv
// ----------------------------------------------------------------------------
// Bone spring-damper force
// Spring and damping force along a bone, magnitude clamp, and tangential
// damping on the rotating end of a hinged bone.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                  Handshake
//   request   start, busy, req_*     word taken when start is high, busy low
//   response  rsp_valid, rsp_*       one cycle per word, no back-pressure
//   config    csr_wr_en, csr_wr_data register written when csr_wr_en is high
//
// One bone is taken every cycle; busy is never raised. Each word passes through
// three front stages (differences, squares, sum), a 28-stage square root, a
// 17-stage divider and nine force stages. Reset clears the valid bits of every
// stage and sets max_force to 0.5. The pipeline never stalls, since the
// receiver cannot hold results off.
//
module bone_spring_damper_force
   import bsdf_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [POS_W-1:0]   req_pos_a_x,
   input  logic signed [POS_W-1:0]   req_pos_a_y,
   input  logic signed [POS_W-1:0]   req_pos_b_x,
   input  logic signed [POS_W-1:0]   req_pos_b_y,
   input  logic signed [VEL_W-1:0]   req_vel_a_x,
   input  logic signed [VEL_W-1:0]   req_vel_a_y,
   input  logic signed [VEL_W-1:0]   req_vel_b_x,
   input  logic signed [VEL_W-1:0]   req_vel_b_y,
   input  logic [LEN_W-1:0]          req_rest_length,
   input  logic [LEN_W-1:0]          req_spring_stiffness,
   input  logic [HINGE_W-1:0]        req_hinge_end,
   input  logic signed [DAMP_W-1:0]  req_rot_damping,
   output logic                      rsp_valid,
   output logic signed [FORCE_W-1:0] rsp_force_x,
   output logic signed [FORCE_W-1:0] rsp_force_y,
   output logic signed [ROT_W-1:0]   rsp_rot_force_x,
   output logic signed [ROT_W-1:0]   rsp_rot_force_y,
   output logic [HINGE_W-1:0]        rsp_rot_target,
   output logic                      rsp_skipped,
   input  logic                      csr_wr_en,
   input  logic [LEN_W-1:0]          csr_wr_data
);

   localparam logic [LEN_W-1:0] MAX_FORCE_RESET = LEN_W'(32768);

   logic [LEN_W-1:0] max_force_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_force_ff <= MAX_FORCE_RESET;
      end else if (csr_wr_en) begin
         max_force_ff <= csr_wr_data;
      end
   end

   assign busy = 1'b0;

   // Front stage 0: differences.
   logic          accept;
   bone_side_type side_in, s0_side_ff, s1_side_ff, s2_side_in, s2_side_ff;
   logic          s0_valid_ff, s1_valid_ff, s2_valid_ff;

   assign accept = start && !busy;

   always_comb begin
      side_in.dx    = DIFF_W'(req_pos_b_x) - DIFF_W'(req_pos_a_x);
      side_in.dy    = DIFF_W'(req_pos_b_y) - DIFF_W'(req_pos_a_y);
      side_in.rvx   = RV_W'(req_vel_b_x) - RV_W'(req_vel_a_x);
      side_in.rvy   = RV_W'(req_vel_b_y) - RV_W'(req_vel_a_y);
      side_in.vax   = req_vel_a_x;
      side_in.vay   = req_vel_a_y;
      side_in.vbx   = req_vel_b_x;
      side_in.vby   = req_vel_b_y;
      side_in.rest  = req_rest_length;
      side_in.k     = req_spring_stiffness;
      side_in.hinge = req_hinge_end;
      side_in.damp  = req_rot_damping;
      side_in.skip  = 1'b0;
   end

   always_ff @(posedge clock) begin
      s0_side_ff <= side_in;
   end

   // Front stage 1: squares of the magnitudes.
   logic [DIFF_W-1:0] mag_x, mag_y;
   logic [RAD_W-1:0]  sq_x_ff, sq_y_ff;

   assign mag_x = s0_side_ff.dx[DIFF_W-1] ? DIFF_W'(-s0_side_ff.dx) : DIFF_W'(s0_side_ff.dx);
   assign mag_y = s0_side_ff.dy[DIFF_W-1] ? DIFF_W'(-s0_side_ff.dy) : DIFF_W'(s0_side_ff.dy);

   always_ff @(posedge clock) begin
      sq_x_ff    <= mag_x * mag_x;
      sq_y_ff    <= mag_y * mag_y;
      s1_side_ff <= s0_side_ff;
   end

   // Front stage 2: sum of squares. The ends coincide only when it is zero.
   logic [RAD_W-1:0] sum_in, sum_ff;

   assign sum_in = sq_x_ff + sq_y_ff;

   always_comb begin
      s2_side_in      = s1_side_ff;
      s2_side_in.skip = (sum_in == '0);
   end

   always_ff @(posedge clock) begin
      sum_ff     <= sum_in;
      s2_side_ff <= s2_side_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= accept;
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   logic              sq_valid;
   logic [ROOT_W-1:0] sq_root;
   bone_side_type     sq_side;

   bsdf_sqrt u_sqrt (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (s2_valid_ff),
      .in_radicand (sum_ff),
      .in_side     (s2_side_ff),
      .out_valid   (sq_valid),
      .out_root    (sq_root),
      .out_side    (sq_side)
   );

   logic              dv_valid;
   logic [QUOT_W-1:0] dv_qx, dv_qy;
   logic [ROOT_W-1:0] dv_dist;
   bone_side_type     dv_side;

   bsdf_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_dist   (sq_root),
      .in_side   (sq_side),
      .out_valid (dv_valid),
      .out_qx    (dv_qx),
      .out_qy    (dv_qy),
      .out_dist  (dv_dist),
      .out_side  (dv_side)
   );

   bsdf_force u_force (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (dv_valid),
      .in_qx           (dv_qx),
      .in_qy           (dv_qy),
      .in_dist         (dv_dist),
      .in_side         (dv_side),
      .max_force       (max_force_ff),
      .out_valid       (rsp_valid),
      .out_force_x     (rsp_force_x),
      .out_force_y     (rsp_force_y),
      .out_rot_force_x (rsp_rot_force_x),
      .out_rot_force_y (rsp_rot_force_y),
      .out_rot_target  (rsp_rot_target),
      .out_skipped     (rsp_skipped)
   );

   // Every word taken yields its result.
   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("result missing after fixed latency");

   // A skipped bone carries no force at all.
   a_skip_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_skipped) |-> (rsp_force_x == '0 && rsp_force_y == '0 &&
                                     rsp_rot_force_x == '0 && rsp_rot_force_y == '0 &&
                                     rsp_rot_target == TARGET_NONE))
      else $error("skipped bone with nonzero force");

   // Without a rotating end there is no tangential force.
   a_rot_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_rot_target == TARGET_NONE) |->
         (rsp_rot_force_x == '0 && rsp_rot_force_y == '0))
      else $error("tangential force without a target");

   // The bone force stays within its saturation bounds.
   a_force_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_force_x <= FORCE_W'(FORCE_LIM) && rsp_force_x >= -FORCE_W'(FORCE_LIM) &&
                     rsp_force_y <= FORCE_W'(FORCE_LIM) && rsp_force_y >= -FORCE_W'(FORCE_LIM)))
      else $error("bone force out of range");

endmodule
